FILE: rtl/rrem_pkg.sv
// Shared types and constants for the row-run edge and midline block.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package rrem_pkg;

    // Column and row counters follow the 9-bit dimension registers
    localparam int COL_W = 9;
    localparam int ROW_W = 9;
    localparam int IDX_W = 8;
    localparam int EDGE_W = 9;
    localparam int MID_W = 10;
    localparam int PIX_W = 8;
    localparam int LIM_W = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 9;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_BIAS_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_ROWS        = 2'd3;

    localparam logic [CFG_DATA_W-1:0] RST_IMAGE_WIDTH  = 9'd160;
    localparam logic [CFG_DATA_W-1:0] RST_IMAGE_HEIGHT = 9'd120;
    localparam logic [LIM_W-1:0]      RST_RIGHT_LIMIT  = 8'd75;
    localparam logic [LIM_W-1:0]      RST_SKIP_ROWS    = 8'd10;

    // floor(x/5) == (x*3277) >> 14 for every x below 16384
    localparam int WSUM_W = 12;
    localparam int RECIP_W = 12;
    localparam int PROD_W = WSUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_5 = 12'd3277;
    localparam int DIV5_SHIFT = 14;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = 2;

    localparam logic signed [MID_W-1:0] MID_NONE = -10'sd1;
    localparam logic signed [EDGE_W-1:0] EDGE_NONE = -9'sd1;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] image_width;
        logic [CFG_DATA_W-1:0] image_height;
        logic [LIM_W-1:0]      right_bias_limit;
        logic [LIM_W-1:0]      skip_rows;
    } rrem_cfg_t;

    // One finished row, as classified by the front end
    typedef struct packed {
        logic [IDX_W-1:0] row_idx;
        logic             has_run;
        logic [COL_W-1:0] left_col;
        logic [COL_W-1:0] right_col;
        logic             wide;      // right edge above the bias limit
        logic             skip;      // row index below skip_rows
        logic             last_row;
    } rrem_rec_t;

endpackage

`default_nettype wire

FILE: rtl/rrem_front.sv
// Front end: per-pixel longest-run tracker and row classification.
// Uses rrem_pkg; pushes one rrem_rec_t per finished row into the queue.
`default_nettype none

module rrem_front import rrem_pkg::*; #(
    parameter int MAX_WIDTH = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire rrem_cfg_t        cfg,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [PIX_W-1:0] s_pixel,
    output logic                  push,
    output rrem_rec_t             push_rec,
    input  wire logic             q_full
);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] run_start_reg, run_start_next;
    logic [COL_W-1:0] run_len_reg, run_len_next;
    logic [COL_W-1:0] best_len_reg, best_len_next;
    logic [COL_W-1:0] best_start_reg, best_start_next;
    logic [COL_W-1:0] best_end_reg, best_end_next;
    logic             stopped_reg, stopped_next;

    logic [COL_W-1:0] w;
    logic [ROW_W-1:0] h;
    logic [COL_W:0]   col_p1;
    logic [ROW_W:0]   row_p1;
    logic [ROW_W-1:0] row_idx;
    logic             eor;
    logic             last_row;
    logic             road;
    logic             accept;

    always_comb begin
        if (cfg.image_width == '0) begin
            w = COL_W'(1);
        end else if (32'(cfg.image_width) > MAX_WIDTH) begin
            w = COL_W'(MAX_WIDTH);
        end else begin
            w = cfg.image_width;
        end
        if (cfg.image_height == '0) begin
            h = ROW_W'(1);
        end else if (32'(cfg.image_height) > MAX_HEIGHT) begin
            h = ROW_W'(MAX_HEIGHT);
        end else begin
            h = cfg.image_height;
        end
    end

    assign road   = (s_pixel != '0);
    assign col_p1 = {1'b0, col_reg} + (COL_W+1)'(1);
    assign eor    = (col_p1 >= {1'b0, w});
    assign row_p1 = {1'b0, row_reg} + (ROW_W+1)'(1);
    assign last_row = (row_p1 >= {1'b0, h});
    assign row_idx  = (row_reg < h) ? (h - ROW_W'(1) - row_reg) : '0;

    // Stall only when this transfer would close a row and the queue has no room
    assign s_ready = !(eor && q_full);
    assign accept  = s_valid && s_ready;
    assign push    = accept && eor;

    always_comb begin
        run_start_next  = run_start_reg;
        run_len_next    = run_len_reg;
        best_len_next   = best_len_reg;
        best_start_next = best_start_reg;
        best_end_next   = best_end_reg;
        stopped_next    = stopped_reg;
        if (!stopped_reg) begin
            if (road) begin
                if (run_len_reg == '0) begin
                    run_start_next = col_reg;
                end
                run_len_next = run_len_reg + COL_W'(1);
                // later run wins a tie
                if (run_len_next >= best_len_reg) begin
                    best_len_next   = run_len_next;
                    best_start_next = run_start_next;
                    best_end_next   = col_reg;
                end
            end else if (best_len_reg > (w >> 1)) begin
                stopped_next = 1'b1;
            end else begin
                run_len_next = '0;
            end
        end
    end

    always_comb begin
        push_rec.row_idx   = row_idx[IDX_W-1:0];
        push_rec.has_run   = (best_len_next != '0);
        push_rec.left_col  = best_start_next;
        push_rec.right_col = best_end_next;
        push_rec.wide      = (best_end_next > {1'b0, cfg.right_bias_limit});
        push_rec.skip      = (row_idx < {1'b0, cfg.skip_rows});
        push_rec.last_row  = last_row;
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (eor) begin
                col_next = '0;
                row_next = last_row ? '0 : row_p1[ROW_W-1:0];
            end else begin
                col_next = col_p1[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg        <= '0;
            row_reg        <= '0;
            run_start_reg  <= '0;
            run_len_reg    <= '0;
            best_len_reg   <= '0;
            best_start_reg <= '0;
            best_end_reg   <= '0;
            stopped_reg    <= 1'b0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (accept) begin
                if (eor) begin
                    run_start_reg  <= '0;
                    run_len_reg    <= '0;
                    best_len_reg   <= '0;
                    best_start_reg <= '0;
                    best_end_reg   <= '0;
                    stopped_reg    <= 1'b0;
                end else begin
                    run_start_reg  <= run_start_next;
                    run_len_reg    <= run_len_next;
                    best_len_reg   <= best_len_next;
                    best_start_reg <= best_start_next;
                    best_end_reg   <= best_end_next;
                    stopped_reg    <= stopped_next;
                end
            end
        end
    end

    // The scan can only stop once some run has been found
    a_stop_needs_run: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |-> (best_len_reg != '0))
        else $error("scan stopped without a best run");

    // The current run never outgrows the best run of the row
    a_run_le_best: assert property (@(posedge aclk) disable iff (!aresetn)
        run_len_reg <= best_len_reg)
        else $error("run length exceeds best length");

endmodule

`default_nettype wire

FILE: rtl/rrem_queue.sv
// Short queue of row records between the front and back ends.
// Uses rrem_pkg for the record type and depth.
`default_nettype none

module rrem_queue import rrem_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire rrem_rec_t push_rec,
    output logic           full,
    input  wire logic      pop,
    output logic           not_empty,
    output rrem_rec_t      head_rec
);

    rrem_rec_t           mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]     count_reg, count_next;

    assign full      = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_rec  = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && !not_empty))
        else $error("pop from empty queue");

endmodule

`default_nettype wire

FILE: rtl/rrem_back.sv
// Back end: midline arithmetic and the result output register.
// Uses rrem_pkg; pops row records from rrem_queue.
`default_nettype none

module rrem_back import rrem_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     q_not_empty,
    input  wire rrem_rec_t                q_rec,
    output logic                          pop,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic        [IDX_W-1:0]       m_row_index,
    output logic signed [EDGE_W-1:0]      m_left_edge,
    output logic signed [EDGE_W-1:0]      m_right_edge,
    output logic signed [MID_W-1:0]       m_midline
);

    // stage 1: weighted sum times reciprocal, average of the edges plus two
    logic                   v1_reg;
    rrem_rec_t              rec1_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [MID_W-1:0]       avg_reg;

    logic                   out_valid_reg;
    logic [IDX_W-1:0]       row_out_reg;
    logic signed [EDGE_W-1:0] left_out_reg, right_out_reg;
    logic signed [MID_W-1:0]  mid_out_reg;
    logic signed [MID_W-1:0]  mid_below_reg, mid_below_next;

    logic [WSUM_W-1:0]      wsum;
    logic [PROD_W-1:0]      prod;
    logic [COL_W:0]         pair_sum;
    logic [MID_W-1:0]       avg;
    logic signed [MID_W-1:0] mid;
    logic                   load_out;
    logic                   load_s1;

    assign load_out = !out_valid_reg || m_ready;
    assign load_s1  = !v1_reg || load_out;
    assign pop      = q_not_empty && load_s1;

    assign wsum = WSUM_W'({q_rec.left_col, 1'b0}) + WSUM_W'({q_rec.right_col, 1'b0})
                + WSUM_W'(q_rec.right_col);
    assign prod = PROD_W'(wsum) * PROD_W'(RECIP_5);
    assign pair_sum = {1'b0, q_rec.left_col} + {1'b0, q_rec.right_col};
    assign avg = {1'b0, pair_sum[COL_W:1]} + MID_W'(2);

    always_comb begin
        priority if (rec1_reg.skip) begin
            mid = MID_NONE;
        end else if (!rec1_reg.has_run) begin
            mid = mid_below_reg;
        end else if (rec1_reg.wide) begin
            mid = $signed(prod_reg[DIV5_SHIFT +: MID_W]);
        end else begin
            mid = $signed(avg_reg);
        end
        mid_below_next = rec1_reg.last_row ? MID_NONE : mid;
    end

    always_ff @(posedge aclk) begin
        if (load_s1) begin
            rec1_reg <= q_rec;
            prod_reg <= prod;
            avg_reg  <= avg;
        end
        if (load_out && v1_reg) begin
            row_out_reg   <= rec1_reg.row_idx;
            left_out_reg  <= rec1_reg.has_run ? $signed(rec1_reg.left_col) : EDGE_NONE;
            right_out_reg <= rec1_reg.has_run ? $signed(rec1_reg.right_col) : EDGE_NONE;
            mid_out_reg   <= mid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            mid_below_reg <= MID_NONE;
        end else begin
            if (load_s1) begin
                v1_reg <= q_not_empty;
            end
            if (load_out) begin
                out_valid_reg <= v1_reg;
            end
            if (load_out && v1_reg) begin
                mid_below_reg <= mid_below_next;
            end
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_row_index  = row_out_reg;
    assign m_left_edge  = left_out_reg;
    assign m_right_edge = right_out_reg;
    assign m_midline    = mid_out_reg;

    // A row with no run reports both edges as none
    a_edges_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_left_edge == EDGE_NONE)) |-> (m_right_edge == EDGE_NONE))
        else $error("only one edge reported as none");

    // A stalled result holds while the next row waits in stage 1
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_midline) && $stable(mid_below_reg))
        else $error("result or midline history changed under stall");

endmodule

`default_nettype wire

FILE: rtl/row_run_edge_and_midline_top.sv
// Top level: configuration registers, front end, row queue and back end.
// Uses rrem_pkg, rrem_front, rrem_queue and rrem_back.
//
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    s_pixel: one mask pixel, bottom row first
//  m_        out        m_valid / m_ready    m_row_index, m_left_edge, m_right_edge, m_midline
//  cfg_      in         cfg_wr_en            cfg_index, cfg_wdata (no read-back)
//
// One pixel transfer per cycle unless stalled; row results pass queue, stage 1, output reg.
// Back end takes one row record per cycle while m_ready is high; single-pixel rows keep up.
// Synchronous active-low reset clears counters, queue and midline history.
// The input stalls only on a row's last pixel while the 4-entry row queue is full.
`default_nettype none

module row_run_edge_and_midline_top import rrem_pkg::*; #(
    parameter int MAX_WIDTH = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [PIX_W-1:0]          s_pixel,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic        [IDX_W-1:0]        m_row_index,
    output logic signed [EDGE_W-1:0]       m_left_edge,
    output logic signed [EDGE_W-1:0]       m_right_edge,
    output logic signed [MID_W-1:0]        m_midline
);

    rrem_cfg_t  cfg_reg;
    logic       push, pop, q_full, q_not_empty;
    rrem_rec_t  push_rec, head_rec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width      <= RST_IMAGE_WIDTH;
            cfg_reg.image_height     <= RST_IMAGE_HEIGHT;
            cfg_reg.right_bias_limit <= RST_RIGHT_LIMIT;
            cfg_reg.skip_rows        <= RST_SKIP_ROWS;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:      cfg_reg.image_width      <= cfg_wdata;
                REG_IMAGE_HEIGHT:     cfg_reg.image_height     <= cfg_wdata;
                REG_RIGHT_BIAS_LIMIT: cfg_reg.right_bias_limit <= cfg_wdata[LIM_W-1:0];
                REG_SKIP_ROWS:        cfg_reg.skip_rows        <= cfg_wdata[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    rrem_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_pixel  (s_pixel),
        .push     (push),
        .push_rec (push_rec),
        .q_full   (q_full)
    );

    rrem_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_rec  (push_rec),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head_rec  (head_rec)
    );

    rrem_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_not_empty  (q_not_empty),
        .q_rec        (head_rec),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_row_index  (m_row_index),
        .m_left_edge  (m_left_edge),
        .m_right_edge (m_right_edge),
        .m_midline    (m_midline)
    );

endmodule

`default_nettype wire

FILE: tb/rrem_checker.sv
// Row-run checker: watches the pixel, result and register ports of the row scanner.
// Keeps its own row-scan model and compares every row result field by field.
// Depends on rrem_pkg for widths, register indexes and reset values.

module rrem_checker import rrem_pkg::*; #(
    parameter int MAX_WIDTH = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    input  wire logic                  s_ready,
    input  wire logic [PIX_W-1:0]      s_pixel,
    input  wire logic                  m_valid,
    input  wire logic                  m_ready,
    input  wire logic [IDX_W-1:0]      m_row_index,
    input  wire logic signed [EDGE_W-1:0] m_left_edge,
    input  wire logic signed [EDGE_W-1:0] m_right_edge,
    input  wire logic signed [MID_W-1:0]  m_midline,
    output int                         mismatches,
    output int                         rows_due,
    output int                         rows_checked
);

    typedef struct packed {
        logic [IDX_W-1:0]  row_index;
        logic [EDGE_W-1:0] left_edge;
        logic [EDGE_W-1:0] right_edge;
        logic [MID_W-1:0]  midline;
    } row_result_t;

    row_result_t row_results_due[$];

    // register mirror
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic [LIM_W-1:0]      limit_reg;
    logic [LIM_W-1:0]      skip_reg;

    // scan state
    logic [COL_W-1:0]      col_count;
    logic [ROW_W-1:0]      row_count;
    logic [COL_W-1:0]      run_start;
    logic [COL_W-1:0]      run_len;
    logic [COL_W-1:0]      best_len;
    logic [COL_W-1:0]      best_start;
    logic [COL_W-1:0]      best_end;
    logic                  stopped;
    logic signed [MID_W-1:0] mid_below;

    function automatic int dim_clamp(input int v, input int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic clear_row_scan();
        col_count = '0;
        run_start = '0;
        run_len = '0;
        best_len = '0;
        best_start = '0;
        best_end = '0;
        stopped = 1'b0;
    endtask

    task automatic scan_pixel(input logic [PIX_W-1:0] pix);
        int w, h, col, idx, left, right, mid;
        logic last_row;
        row_result_t res;
        w = dim_clamp(width_reg, MAX_WIDTH);
        h = dim_clamp(height_reg, MAX_HEIGHT);
        col = col_count;
        if (!stopped) begin
            if (pix != '0) begin
                if (run_len == '0) run_start = COL_W'(col);
                run_len = run_len + 1'b1;
                // later run wins a tie
                if (run_len >= best_len) begin
                    best_len = run_len;
                    best_start = run_start;
                    best_end = COL_W'(col);
                end
            end else if (int'(best_len) > w / 2) begin
                stopped = 1'b1;
            end else begin
                run_len = '0;
            end
        end
        if (col + 1 < w) begin
            col_count = COL_W'(col + 1);
            return;
        end

        last_row = (int'(row_count) + 1 >= h);
        // a row past a shrunken height counts as the top row
        idx = (int'(row_count) < h) ? h - 1 - int'(row_count) : 0;
        if (best_len != '0) begin
            left = best_start;
            right = best_end;
        end else begin
            left = -1;
            right = -1;
        end
        if (idx < int'(skip_reg))
            mid = -1;
        else if (left < 0)
            mid = mid_below;
        else if (right > int'(limit_reg))
            mid = (2 * left + 3 * right) / 5;
        else
            mid = (left + right) / 2 + 2;

        res.row_index = idx[IDX_W-1:0];
        res.left_edge = left[EDGE_W-1:0];
        res.right_edge = right[EDGE_W-1:0];
        res.midline = mid[MID_W-1:0];
        row_results_due.push_back(res);

        clear_row_scan();
        if (last_row) begin
            row_count = '0;
            mid_below = MID_NONE;
        end else begin
            row_count = row_count + 1'b1;
            mid_below = mid[MID_W-1:0];
        end
    endtask

    task automatic check_row_result();
        row_result_t want;
        if (row_results_due.size() == 0) begin
            report_mismatch($sformatf("row result for row %0d with none due", m_row_index));
            return;
        end
        want = row_results_due.pop_front();
        rows_checked++;
        if (m_row_index !== want.row_index)
            report_mismatch($sformatf("row_index got %0d, expected %0d",
                                      m_row_index, want.row_index));
        if (m_left_edge !== $signed(want.left_edge))
            report_mismatch($sformatf("row %0d left_edge got %0d, expected %0d",
                                      want.row_index, m_left_edge, $signed(want.left_edge)));
        if (m_right_edge !== $signed(want.right_edge))
            report_mismatch($sformatf("row %0d right_edge got %0d, expected %0d",
                                      want.row_index, m_right_edge, $signed(want.right_edge)));
        if (m_midline !== $signed(want.midline))
            report_mismatch($sformatf("row %0d midline got %0d, expected %0d",
                                      want.row_index, m_midline, $signed(want.midline)));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg = RST_IMAGE_WIDTH;
            height_reg = RST_IMAGE_HEIGHT;
            limit_reg = RST_RIGHT_LIMIT;
            skip_reg = RST_SKIP_ROWS;
            clear_row_scan();
            row_count = '0;
            mid_below = MID_NONE;
            row_results_due.delete();
            mismatches = 0;
            rows_checked = 0;
        end else begin
            if (m_valid && m_ready) check_row_result();
            if (s_valid && s_ready) scan_pixel(s_pixel);
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:      width_reg = cfg_wdata;
                    REG_IMAGE_HEIGHT:     height_reg = cfg_wdata;
                    REG_RIGHT_BIAS_LIMIT: limit_reg = cfg_wdata[LIM_W-1:0];
                    REG_SKIP_ROWS:        skip_reg = cfg_wdata[LIM_W-1:0];
                    default: ;
                endcase
            end
        end
        rows_due = row_results_due.size();
    end

endmodule

FILE: tb/tb.sv
// Top of the row scanner testbench: clock, reset, register setup, pixel and ready drivers.
// Instantiates row_run_edge_and_midline_top and rrem_checker; uses rrem_pkg.

module tb;
    import rrem_pkg::*;

    localparam int MAX_WIDTH = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int PIXEL_BUDGET = 600;
    localparam int RUN_LIMIT = 2_000_000;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_wr_en;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_wdata;
    logic                     s_valid;
    logic                     s_ready;
    logic [PIX_W-1:0]         s_pixel;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [IDX_W-1:0]         m_row_index;
    logic signed [EDGE_W-1:0] m_left_edge;
    logic signed [EDGE_W-1:0] m_right_edge;
    logic signed [MID_W-1:0]  m_midline;

    int mismatches;
    int rows_due;
    int rows_checked;

    int pixels_sent = 0;
    int settings_used = 0;
    int burst_left = 0;
    int row_width = 160;
    int flip_odds = 4;
    bit road_now = 1'b0;
    rx_mode_t rx_mode = RX_OPEN;
    int rx_left = 0;

    // five rows of width 5: empty bottom row, a tie with a wide midline,
    // a narrow midline after an early stop, an empty row copying the one below,
    // and a row in the skip band
    logic [PIX_W-1:0] directed_pixels [25] = '{
        8'd0,   8'd0, 8'd0,   8'd0, 8'd0,
        8'd255, 8'd0, 8'd128, 8'd1, 8'd0,
        8'd1,   8'd1, 8'd1,   8'd0, 8'd1,
        8'd0,   8'd0, 8'd0,   8'd0, 8'd0,
        8'd1,   8'd0, 8'd0,   8'd64, 8'd0
    };

    row_run_edge_and_midline_top #(
        .MAX_WIDTH(MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_pixel(s_pixel),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_row_index(m_row_index),
        .m_left_edge(m_left_edge),
        .m_right_edge(m_right_edge),
        .m_midline(m_midline)
    );

    rrem_checker #(
        .MAX_WIDTH(MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) row_checker (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_pixel(s_pixel),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_row_index(m_row_index),
        .m_left_edge(m_left_edge),
        .m_right_edge(m_right_edge),
        .m_midline(m_midline),
        .mismatches(mismatches),
        .rows_due(rows_due),
        .rows_checked(rows_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("timeout with %0d row results still due", rows_due);
        $display("end of test: mismatches");
        $finish;
    end

    // receiver: ready pattern switches among random modes
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 20) : $urandom_range(8, 60);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
            default:   m_ready <= 1'b0;
        endcase
    end

    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_pixel <= pix;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        pixels_sent++;
    endtask

    // rows of runs with random flip rate; some rows empty or solid, a little noise
    task automatic send_pixels(input int count);
        int style;
        for (int i = 0; i < count; i++) begin
            if (i % row_width == 0) begin
                style = $urandom_range(0, 7);
                flip_odds = (style < 2) ? 1000000 : $urandom_range(1, 10);
                road_now = (style == 1) || (style > 1 && $urandom_range(0, 1) == 1);
            end
            if ($urandom_range(0, flip_odds) == 0) road_now = !road_now;
            if (style > 1 && $urandom_range(0, 15) == 0)
                send_pixel(PIX_W'($urandom_range(0, 255)));
            else
                send_pixel(road_now ? PIX_W'($urandom_range(1, 255)) : '0);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[CFG_DATA_W-1:0];
    endtask

    // wait until the block is idle, then load all four registers
    task automatic program_regs(input int w, input int h, input int lim, input int skip);
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (rows_due == 0);
        // pixels that end no row may still be in the pipeline
        repeat (8) @(posedge aclk);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_RIGHT_BIAS_LIMIT, lim);
        write_reg(REG_SKIP_ROWS, skip);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        row_width = (w < 1) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
        burst_left = 0;
        settings_used++;
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_IMAGE_WIDTH;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_pixel = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        program_regs(5, 12, 2, 8);
        foreach (directed_pixels[i]) send_pixel(directed_pixels[i]);

        // eleven-row frame with wrap, limit and skip at zero
        program_regs(4, 11, 0, 0);
        send_pixels(56);
        // width zero clamps to one; tallest frame; limit and skip at top
        program_regs(0, 256, 255, 255);
        send_pixels(40);
        // height zero clamps to one: every row is the top row
        program_regs(1, 0, 128, 0);
        send_pixels(20);
        // oversize width clamps to the maximum; long run then a zero
        program_regs(300, 12, 128, 3);
        repeat (140) send_pixel(PIX_W'($urandom_range(1, 255)));
        send_pixel(0);
        send_pixels(115);
        // ends mid-row; next setting widens the row and drops height below the row count
        program_regs(8, 20, 5, 10);
        send_pixels(51);
        program_regs(12, 5, 40, 0);
        send_pixels(60);
        // ends mid-row; next setting narrows the width below the current column
        program_regs(10, 11, 7, 2);
        send_pixels(47);
        program_regs(3, 30, 1, 4);
        send_pixels(30);

        while (pixels_sent < PIXEL_BUDGET) begin
            program_regs($urandom_range(1, 24),
                         ($urandom_range(0, 5) == 0) ? $urandom_range(0, 10)
                                                      : $urandom_range(11, 40),
                         ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                      : $urandom_range(0, 30),
                         ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                      : $urandom_range(0, 12));
            send_pixels(row_width * $urandom_range(3, 8)
                        + (($urandom_range(0, 2) == 0) ? $urandom_range(1, row_width) : 0));
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        wait (rows_due == 0);
        repeat (10) @(posedge aclk);

        $display("sent %0d pixels under %0d register settings", pixels_sent, settings_used);
        $display("compared %0d row results, %0d still due", rows_checked, rows_due);
        if (mismatches == 0 && rows_due == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/rrem_pkg.sv
rtl/rrem_front.sv
rtl/rrem_queue.sv
rtl/rrem_back.sv
rtl/row_run_edge_and_midline_top.sv
tb/rrem_checker.sv
tb/tb.sv
